[hdl/utf8s_pkg.sv]
// Shared widths, constants and types for the UTF-8 sequence sanitizer.
`default_nettype none

package utf8s_pkg;

  localparam int BYTE_W   = 8;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;
  localparam int GROUP_SZ = 4;

  // Word index of the replacement byte register.
  localparam logic REG_IDX_REPL = 1'b0;

  localparam logic [BYTE_W-1:0] REPL_RESET = 8'h3F;

  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
  localparam logic [BYTE_W-1:0] CONT_PAT   = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_PAT  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_PAT  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD4_PAT  = 8'hF0;

  // All output bytes caused by one input transaction.
  typedef struct packed {
    logic [GROUP_SZ-1:0][BYTE_W-1:0] bytes;
    logic [2:0]                      count;
    logic                            fin;
  } utf8s_group_t;

endpackage : utf8s_pkg

`default_nettype wire

[hdl/utf8s_stream_if.sv]
// Valid/ready stream interfaces for the input and result channels.
`default_nettype none

interface utf8s_in_if import utf8s_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              is_final;

  modport source (output valid, output in_byte, output is_final, input ready);
  modport sink   (input valid, input in_byte, input is_final, output ready);
endinterface : utf8s_in_if

interface utf8s_out_if import utf8s_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              run_last;
  logic              string_end;

  modport source (output valid, output out_byte, output run_last, output string_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input string_end,
                  output ready);
endinterface : utf8s_out_if

`default_nettype wire

[hdl/utf8_sequence_sanitizer_unit.sv]
// Top level of the UTF-8 sequence sanitizer.
// The block accepts one byte transaction per cycle unless stalled, and sends
// each result byte as its own transaction; a byte is registered, its output
// group (zero to four bytes) is formed in one pass and stored in the result
// register. The result channel moves one byte per cycle while the receiver is
// ready; the input side stalls while the result register holds unsent bytes,
// and a byte that causes no result (a lead byte that opens a sequence, or a
// middle continuation byte) leaves the result register unchanged.
// The replacement byte register resets to 0x3F and is written over APB at
// address 0.
`default_nettype none

module utf8_sequence_sanitizer_unit import utf8s_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  utf8s_in_if.sink               in_ch,
  utf8s_out_if.source            out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_fin_r;
  logic              grp_free;
  logic              advance;
  logic [BYTE_W-1:0] repl_byte;
  utf8s_group_t      group;

  assign advance     = in_valid_r && grp_free;
  assign in_ch.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.in_byte;
      in_fin_r  <= in_ch.is_final;
    end
  end

  utf8s_apb_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .repl_byte (repl_byte)
  );

  utf8s_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .cur_byte  (in_byte_r),
    .cur_fin   (in_fin_r),
    .repl_byte (repl_byte),
    .group     (group)
  );

  utf8s_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (advance),
    .group    (group),
    .grp_free (grp_free),
    .out_ch   (out_ch)
  );

endmodule : utf8_sequence_sanitizer_unit

`default_nettype wire

[hdl/utf8s_apb_regs.sv]
// APB register block holding the replacement byte.
`default_nettype none

module utf8s_apb_regs import utf8s_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output logic      [BYTE_W-1:0] repl_byte
);

  logic [BYTE_W-1:0] repl_r;
  logic              wr_hit;

  assign pready    = 1'b1;
  assign wr_hit    = psel && penable && pwrite && (paddr[2] == REG_IDX_REPL);
  assign repl_byte = repl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repl_r <= REPL_RESET;
    end else if (wr_hit) begin
      repl_r <= pwdata[BYTE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_IDX_REPL) begin
      prdata = {{(APB_DW-BYTE_W){1'b0}}, repl_r};
    end
  end

endmodule : utf8s_apb_regs

`default_nettype wire

[hdl/utf8s_seq.sv]
// Sequence tracker: holds an open UTF-8 sequence and forms the output group per byte.
`default_nettype none

module utf8s_seq import utf8s_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              advance,
  input  wire logic [BYTE_W-1:0] cur_byte,
  input  wire logic              cur_fin,
  input  wire logic [BYTE_W-1:0] repl_byte,
  output utf8s_group_t           group
);

  logic [BYTE_W-1:0] held_r [3];
  logic [1:0]        cnt_r;
  logic [1:0]        cnt_nxt;
  logic [2:0]        exp_r;
  logic [2:0]        exp_nxt;
  logic              held_we;
  logic [1:0]        held_idx;

  function automatic logic [2:0] lead_len(input logic [BYTE_W-1:0] b);
    logic [2:0] len;
    len = 3'd0;
    if ((b & LEAD2_MASK) == LEAD2_PAT) begin
      len = 3'd2;
    end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
      len = 3'd3;
    end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
      len = 3'd4;
    end
    return len;
  endfunction

  always_comb begin
    logic [GROUP_SZ-1:0][BYTE_W-1:0] slots;
    logic [2:0]                      n;
    logic [2:0]                      len;
    logic [1:0]                      flush_cnt;
    logic                            is_cont;

    slots    = '0;
    n        = 3'd0;
    cnt_nxt  = cnt_r;
    exp_nxt  = exp_r;
    held_we  = 1'b0;
    held_idx = cnt_r;
    is_cont  = (cur_byte & CONT_MASK) == CONT_PAT;
    len      = lead_len(cur_byte);

    if ((exp_r != 3'd0) && is_cont) begin
      if (({1'b0, cnt_r} + 3'd1) >= exp_r) begin
        for (int i = 0; i < 3; i++) begin
          if ((2'(i) < cnt_r) && (n != 3'd4)) begin
            slots[n[1:0]] = held_r[i];
            n = n + 3'd1;
          end
        end
        if (n != 3'd4) begin
          slots[n[1:0]] = cur_byte;
          n = n + 3'd1;
        end
        cnt_nxt = 2'd0;
        exp_nxt = 3'd0;
      end else begin
        held_we = 1'b1;
        cnt_nxt = cnt_r + 2'd1;
      end
    end else begin
      if (exp_r != 3'd0) begin
        for (int i = 0; i < 3; i++) begin
          if ((2'(i) < cnt_r) && (n != 3'd4)) begin
            slots[n[1:0]] = repl_byte;
            n = n + 3'd1;
          end
        end
        cnt_nxt = 2'd0;
        exp_nxt = 3'd0;
      end
      if (!cur_byte[BYTE_W-1]) begin
        slots[n[1:0]] = cur_byte;
        n = n + 3'd1;
      end else if (len != 3'd0) begin
        held_we  = 1'b1;
        held_idx = 2'd0;
        cnt_nxt  = 2'd1;
        exp_nxt  = len;
      end else begin
        slots[n[1:0]] = repl_byte;
        n = n + 3'd1;
      end
    end

    if (cur_fin && (exp_nxt != 3'd0)) begin
      flush_cnt = cnt_nxt;
      for (int i = 0; i < 3; i++) begin
        if ((2'(i) < flush_cnt) && (n != 3'd4)) begin
          slots[n[1:0]] = repl_byte;
          n = n + 3'd1;
        end
      end
      cnt_nxt = 2'd0;
      exp_nxt = 3'd0;
    end else begin
      flush_cnt = 2'd0;
    end

    group.bytes = slots;
    group.count = n;
    group.fin   = cur_fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      exp_r <= 3'd0;
    end else if (advance) begin
      cnt_r <= cnt_nxt;
      exp_r <= exp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && held_we) begin
      held_r[held_idx] <= cur_byte;
    end
  end

  a_closed_empty : assert property (@(posedge clk) disable iff (!rst_n)
    (exp_r == 3'd0) |-> (cnt_r == 2'd0))
    else $error("held bytes remain with no open sequence");

  a_open_bounds : assert property (@(posedge clk) disable iff (!rst_n)
    (exp_r != 3'd0) |-> ((cnt_r != 2'd0) && ({1'b0, cnt_r} < exp_r) &&
                         (exp_r == 3'd2 || exp_r == 3'd3 || exp_r == 3'd4)))
    else $error("open sequence state is inconsistent");

endmodule : utf8s_seq

`default_nettype wire

[hdl/utf8s_emit.sv]
// Result register: holds a byte group; sends one transaction per cycle while ready.
`default_nettype none

module utf8s_emit import utf8s_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         load,
  input  wire utf8s_group_t group,
  output logic              grp_free,
  utf8s_out_if.source       out_ch
);

  logic [GROUP_SZ-1:0][BYTE_W-1:0] bytes_r;
  logic [2:0]                      n_r;
  logic [1:0]                      pos_r;
  logic                            fin_r;
  logic                            valid_r;
  logic                            is_last;
  logic                            out_fire;

  assign is_last  = ({1'b0, pos_r} + 3'd1) == n_r;
  assign out_fire = valid_r && out_ch.ready;
  assign grp_free = !valid_r || (out_fire && is_last);

  assign out_ch.valid      = valid_r;
  assign out_ch.out_byte   = bytes_r[pos_r];
  assign out_ch.run_last   = is_last;
  assign out_ch.string_end = is_last && fin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pos_r   <= 2'd0;
    end else if (load && (group.count != 3'd0)) begin
      valid_r <= 1'b1;
      pos_r   <= 2'd0;
    end else if (out_fire) begin
      if (is_last) begin
        valid_r <= 1'b0;
      end
      pos_r <= pos_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && (group.count != 3'd0)) begin
      bytes_r <= group.bytes;
      n_r     <= group.count;
      fin_r   <= group.fin;
    end
  end

  a_pos_in_group : assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> ((n_r != 3'd0) && ({1'b0, pos_r} < n_r)))
    else $error("result position outside the stored group");

  a_step_pos : assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !is_last && !load) |=> (valid_r && (pos_r == $past(pos_r) + 2'd1)))
    else $error("group did not advance after a transaction");

endmodule : utf8s_emit

`default_nettype wire
